### hdl/msl_pkg.sv
// ----------------------------------------------------------------------------
// msl_pkg
// Types and constants shared by the motor speed command and status link.
// ----------------------------------------------------------------------------
`default_nettype none

package msl_pkg;

   // operation codes on the request channel
   localparam logic [2:0] OP_SET_TARGET = 3'd0;
   localparam logic [2:0] OP_SEND_RPM   = 3'd1;
   localparam logic [2:0] OP_BRAKE      = 3'd2;
   localparam logic [2:0] OP_RECEIVE    = 3'd3;
   localparam logic [2:0] OP_TICK       = 3'd4;

   // bus packet kinds
   localparam logic [7:0] KIND_NONE   = 8'd0;
   localparam logic [7:0] KIND_BRAKE  = 8'd2;
   localparam logic [7:0] KIND_SPEED  = 8'd3;
   localparam logic [7:0] KIND_STATUS = 8'd9;

   localparam logic [3:0] STATUS_LENGTH = 4'd8;

   // saturation bounds of a signed 32-bit value
   localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S32_MIN = 32'h8000_0000;

   // register file
   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_MOTOR_ADDRESS  = 3'd0,
      REG_POLE_PAIRS     = 3'd1,
      REG_MIN_SPEED      = 3'd2,
      REG_MAX_SPEED      = 3'd3,
      REG_BRAKE_CURRENT  = 3'd4,
      REG_STATUS_TIMEOUT = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  motor_address;
      logic [7:0]  pole_pair_count;
      logic [30:0] min_speed_rpm;
      logic [30:0] max_speed_rpm;
      logic [30:0] brake_current_ma;
      logic [31:0] status_timeout_ms;
   } cfg_type;

   // classified command kinds carried through the queue
   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_SET    = 3'd1,
      CMD_SEND   = 3'd2,
      CMD_BRAKE  = 3'd3,
      CMD_STATUS = 3'd4,
      CMD_TICK   = 3'd5
   } cmd_kind_type;

   // value: limited target for CMD_SET, electrical rpm for CMD_STATUS
   typedef struct packed {
      cmd_kind_type       kind;
      logic signed [31:0] value;
      logic signed [15:0] current;
      logic signed [15:0] duty;
      logic [31:0]        time_ms;
   } cmd_type;

   typedef struct packed {
      logic               frame_accepted;
      logic               tx_valid;
      logic [7:0]         tx_packet_kind;
      logic [7:0]         tx_address;
      logic signed [31:0] tx_value;
      logic signed [31:0] target_speed;
      logic signed [31:0] measured_speed;
      logic signed [15:0] current_deciamps;
      logic signed [15:0] duty_permille;
      logic               link_online;
      logic [31:0]        last_status_ms;
   } result_type;

endpackage

`default_nettype wire

### hdl/msl_if.sv
// ----------------------------------------------------------------------------
// msl_if
// Request and response channel interfaces of the motor link.
// ----------------------------------------------------------------------------
`default_nettype none

interface msl_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         operation;
   logic signed [31:0] requested_rpm;
   logic [7:0]         rx_motor_id;
   logic [7:0]         rx_packet_kind;
   logic [3:0]         rx_length;
   logic [63:0]        rx_payload;
   logic [31:0]        time_now_ms;

   modport source (
      output valid, operation, requested_rpm, rx_motor_id, rx_packet_kind,
             rx_length, rx_payload, time_now_ms,
      input  ready
   );
   modport sink (
      input  valid, operation, requested_rpm, rx_motor_id, rx_packet_kind,
             rx_length, rx_payload, time_now_ms,
      output ready
   );
endinterface

interface msl_rsp_if;
   logic               valid;
   logic               ready;
   logic               frame_accepted;
   logic               tx_valid;
   logic [7:0]         tx_packet_kind;
   logic [7:0]         tx_address;
   logic signed [31:0] tx_value;
   logic signed [31:0] target_speed;
   logic signed [31:0] measured_speed;
   logic signed [15:0] current_deciamps;
   logic signed [15:0] duty_permille;
   logic               link_online;
   logic [31:0]        last_status_ms;

   modport source (
      output valid, frame_accepted, tx_valid, tx_packet_kind, tx_address, tx_value,
             target_speed, measured_speed, current_deciamps, duty_permille,
             link_online, last_status_ms,
      input  ready
   );
   modport sink (
      input  valid, frame_accepted, tx_valid, tx_packet_kind, tx_address, tx_value,
             target_speed, measured_speed, current_deciamps, duty_permille,
             link_online, last_status_ms,
      output ready
   );
endinterface

`default_nettype wire

### hdl/motor_speed_command_status_link_top.sv
// ----------------------------------------------------------------------------
// motor_speed_command_status_link_top
// Motor speed command and status link: target limiting, speed and brake
// command frames, status frame decode and link timeout tracking.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one response transaction that
// carries the frame outcome and the link state after the request. Requests
// are classified on entry and wait in a short queue while the back end works
// on one command at a time. Set target, send rpm, brake, tick, rejected
// frames and unused codes pass through the queue and the command register
// into the response register; an accepted status frame also passes through the
// serial divider that turns electrical rpm into mechanical rpm one quotient
// bit per cycle. A finished response waits in its output register while the
// next request is accepted.
// Registers (byte address 4*i): motor address, pole pairs, minimum speed,
// maximum speed, brake current, status timeout; write them only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_command_status_link_top import msl_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   msl_req_if.sink               req_bus,
   msl_rsp_if.source             rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   cfg_type       cfg_ff;
   reg_index_type reg_index;
   logic          csr_write;
   logic          q_push;
   logic          q_full;
   logic          q_pop;
   logic          q_valid;
   cmd_type       q_push_entry;
   cmd_type       q_pop_entry;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[4:2]);
   assign csr_write = psel && penable && pwrite && pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.motor_address     <= 8'd0;
         cfg_ff.pole_pair_count   <= 8'd1;
         cfg_ff.min_speed_rpm     <= '0;
         cfg_ff.max_speed_rpm     <= '0;
         cfg_ff.brake_current_ma  <= '0;
         cfg_ff.status_timeout_ms <= 32'd100;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_MOTOR_ADDRESS:  cfg_ff.motor_address     <= pwdata[7:0];
            REG_POLE_PAIRS:     cfg_ff.pole_pair_count   <= pwdata[7:0];
            REG_MIN_SPEED:      cfg_ff.min_speed_rpm     <= pwdata[30:0];
            REG_MAX_SPEED:      cfg_ff.max_speed_rpm     <= pwdata[30:0];
            REG_BRAKE_CURRENT:  cfg_ff.brake_current_ma  <= pwdata[30:0];
            REG_STATUS_TIMEOUT: cfg_ff.status_timeout_ms <= pwdata;
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_index)
         REG_MOTOR_ADDRESS:  prdata = {24'd0, cfg_ff.motor_address};
         REG_POLE_PAIRS:     prdata = {24'd0, cfg_ff.pole_pair_count};
         REG_MIN_SPEED:      prdata = {1'b0, cfg_ff.min_speed_rpm};
         REG_MAX_SPEED:      prdata = {1'b0, cfg_ff.max_speed_rpm};
         REG_BRAKE_CURRENT:  prdata = {1'b0, cfg_ff.brake_current_ma};
         REG_STATUS_TIMEOUT: prdata = cfg_ff.status_timeout_ms;
         default:            prdata = '0;
      endcase
   end

   msl_front u_front (
      .req     (req_bus),
      .cfg     (cfg_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_entry (q_push_entry)
   );

   msl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_valid),
      .pop_entry  (q_pop_entry)
   );

   msl_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_entry (q_pop_entry),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

`default_nettype wire

### hdl/msl_front.sv
// ----------------------------------------------------------------------------
// msl_front
// Accepts request transactions, classifies them and pushes commands to the
// queue. Limits set-target speeds and filters received status frames.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_front import msl_pkg::*; (
   msl_req_if.sink  req,
   input  cfg_type  cfg,
   input  logic     q_full,
   output logic     q_push,
   output cmd_type  q_entry
);

   logic        req_neg;
   logic [31:0] req_mag;
   logic signed [31:0] limited;
   logic        frame_match;

   // accept whenever the queue has room
   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   // limit the requested speed: dead band first, then clamp
   always_comb begin
      req_neg = req.requested_rpm[31];
      req_mag = req_neg ? (~req.requested_rpm + 32'd1) : req.requested_rpm;
      if (req_mag < {1'b0, cfg.min_speed_rpm}) begin
         limited = '0;
      end else if (req_mag > {1'b0, cfg.max_speed_rpm}) begin
         limited = req_neg ? -$signed({1'b0, cfg.max_speed_rpm})
                           : $signed({1'b0, cfg.max_speed_rpm});
      end else begin
         limited = req.requested_rpm;
      end
   end

   // status frame for this motor
   assign frame_match = (req.rx_motor_id == cfg.motor_address)
                     && (req.rx_packet_kind == KIND_STATUS)
                     && (req.rx_length == STATUS_LENGTH);

   // classify the transaction
   always_comb begin
      q_entry.kind    = CMD_NONE;
      q_entry.value   = req.rx_payload[63:32];
      q_entry.current = req.rx_payload[31:16];
      q_entry.duty    = req.rx_payload[15:0];
      q_entry.time_ms = req.time_now_ms;
      unique case (req.operation)
         OP_SET_TARGET: begin
            q_entry.kind  = CMD_SET;
            q_entry.value = limited;
         end
         OP_SEND_RPM: q_entry.kind = CMD_SEND;
         OP_BRAKE:    q_entry.kind = CMD_BRAKE;
         OP_RECEIVE:  q_entry.kind = frame_match ? CMD_STATUS : CMD_NONE;
         OP_TICK:     q_entry.kind = CMD_TICK;
         default:     q_entry.kind = CMD_NONE;
      endcase
   end

endmodule

`default_nettype wire

### hdl/msl_queue.sv
// ----------------------------------------------------------------------------
// msl_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_queue import msl_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_entry,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == FULL_CNT);
   assign not_empty = (count_ff != '0);
   assign pop_entry = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

### hdl/msl_div.sv
// ----------------------------------------------------------------------------
// msl_div
// Serial restoring divider: 32-bit dividend by 8-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic [31:0] quotient
);

   logic [31:0] quo_ff, quo_in;
   logic [7:0]  rem_ff, rem_in;
   logic [7:0]  div_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff;
   logic [8:0]  shifted;
   logic        take;

   assign busy     = busy_ff;
   assign quotient = quo_ff;

   // one restoring step
   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      take    = (shifted >= {1'b0, div_ff});
      rem_in  = take ? 8'(shifted - {1'b0, div_ff}) : shifted[7:0];
      quo_in  = {quo_ff[30:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'd31;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

endmodule

`default_nettype wire

### hdl/msl_back.sv
// ----------------------------------------------------------------------------
// msl_back
// Executes queued commands: holds the link state, builds speed and brake
// frames, decodes status frames and drives the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module msl_back import msl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    q_valid,
   input  cmd_type q_entry,
   output logic    q_pop,
   msl_rsp_if.source rsp
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_DONE = 3'b100
   } back_state_type;

   back_state_type     state_ff, state_in;
   cmd_type            cmd_ff;
   logic signed [39:0] prod_ff, prod_in;
   logic signed [31:0] target_ff, target_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [15:0] current_ff, current_in;
   logic signed [15:0] duty_ff, duty_in;
   logic               online_ff, online_in;
   logic [31:0]        last_ff, last_in;
   result_type         res_ff, res_in;
   logic               res_valid_ff, res_valid_in;

   logic               out_free;
   logic               commit;
   logic               div_start;
   logic               div_busy;
   logic [31:0]        div_quot;
   logic [31:0]        erpm_mag;
   logic [31:0]        dividend;
   logic [7:0]         divisor;
   logic signed [31:0] tx_speed;
   logic [31:0]        elapsed;

   assign out_free  = !res_valid_ff || rsp.ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;
   assign commit    = (state_ff == ST_DONE) && out_free;
   assign div_start = q_pop && (q_entry.kind == CMD_STATUS);

   // rounded decode: magnitude plus half the divisor
   always_comb begin
      erpm_mag = q_entry.value[31] ? (~q_entry.value + 32'd1) : q_entry.value;
      dividend = erpm_mag + {25'd0, cfg.pole_pair_count[7:1]};
      divisor  = (cfg.pole_pair_count == '0) ? 8'd1 : cfg.pole_pair_count;
   end

   msl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // electrical rpm product, saturated when the frame is built
   assign prod_in = $signed(target_ff) * $signed({1'b0, cfg.pole_pair_count});

   always_comb begin
      if ((prod_ff[39:31] == '0) || (prod_ff[39:31] == '1)) begin
         tx_speed = prod_ff[31:0];
      end else begin
         tx_speed = prod_ff[39] ? S32_MIN : S32_MAX;
      end
   end

   // sequence one command at a time
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               state_in = (q_entry.kind == CMD_STATUS) ? ST_DIV : ST_DONE;
            end
         end
         ST_DIV: begin
            if (!div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // carry out the command and build the response
   always_comb begin
      target_in  = target_ff;
      speed_in   = speed_ff;
      current_in = current_ff;
      duty_in    = duty_ff;
      online_in  = online_ff;
      last_in    = last_ff;
      elapsed    = cmd_ff.time_ms - last_ff;

      res_in                = '0;
      res_in.tx_packet_kind = KIND_NONE;

      case (cmd_ff.kind)
         CMD_SET: target_in = cmd_ff.value;
         CMD_SEND: begin
            res_in.tx_valid       = 1'b1;
            res_in.tx_packet_kind = KIND_SPEED;
            res_in.tx_address     = cfg.motor_address;
            res_in.tx_value       = tx_speed;
         end
         CMD_BRAKE: begin
            target_in             = '0;
            res_in.tx_valid       = 1'b1;
            res_in.tx_packet_kind = KIND_BRAKE;
            res_in.tx_address     = cfg.motor_address;
            res_in.tx_value       = $signed({1'b0, cfg.brake_current_ma});
         end
         CMD_STATUS: begin
            res_in.frame_accepted = 1'b1;
            speed_in   = cmd_ff.value[31] ? -$signed(div_quot) : $signed(div_quot);
            current_in = cmd_ff.current;
            duty_in    = cmd_ff.duty;
            online_in  = 1'b1;
            last_in    = cmd_ff.time_ms;
         end
         CMD_TICK: begin
            if ((last_ff == '0) || (elapsed > cfg.status_timeout_ms)) begin
               online_in = 1'b0;
            end
         end
         default: ;
      endcase

      res_in.target_speed     = target_in;
      res_in.measured_speed   = speed_in;
      res_in.current_deciamps = current_in;
      res_in.duty_permille    = duty_in;
      res_in.link_online      = online_in;
      res_in.last_status_ms   = last_in;

      if (commit) begin
         res_valid_in = 1'b1;
      end else begin
         res_valid_in = res_valid_ff && !rsp.ready;
      end
   end

   // control and link state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         res_valid_ff <= 1'b0;
         target_ff    <= '0;
         speed_ff     <= '0;
         current_ff   <= '0;
         duty_ff      <= '0;
         online_ff    <= 1'b0;
         last_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         if (commit) begin
            target_ff  <= target_in;
            speed_ff   <= speed_in;
            current_ff <= current_in;
            duty_ff    <= duty_in;
            online_ff  <= online_in;
            last_ff    <= last_in;
         end
      end
   end

   // hold the command, product and response payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cmd_ff  <= q_entry;
         prod_ff <= prod_in;
      end
      if (commit) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid            = res_valid_ff;
   assign rsp.frame_accepted   = res_ff.frame_accepted;
   assign rsp.tx_valid         = res_ff.tx_valid;
   assign rsp.tx_packet_kind   = res_ff.tx_packet_kind;
   assign rsp.tx_address       = res_ff.tx_address;
   assign rsp.tx_value         = res_ff.tx_value;
   assign rsp.target_speed     = res_ff.target_speed;
   assign rsp.measured_speed   = res_ff.measured_speed;
   assign rsp.current_deciamps = res_ff.current_deciamps;
   assign rsp.duty_permille    = res_ff.duty_permille;
   assign rsp.link_online      = res_ff.link_online;
   assign rsp.last_status_ms   = res_ff.last_status_ms;

endmodule

`default_nettype wire
